>>> rtl/core/csx_pkg.sv
// Package for the CAN signal extract and scale unit.
// Holds field widths, register indexes, codes and the configuration struct.
// No dependencies; every other file but csx_checker uses it by scoped names.
`timescale 1ns / 1ps

package csx_pkg;

  localparam int PAYLOAD_W   = 64;
  localparam int NBYTES_W    = 4;
  localparam int START_W     = 6;
  localparam int LEN_W       = 7;
  localparam int FACTOR_W    = 32;
  localparam int OFFSET_W    = 64;
  localparam int RAW_W       = 64;
  localparam int PHYS_W      = 64;
  localparam int PROD_W      = RAW_W + FACTOR_W;   // unsigned product magnitude
  localparam int SUM_W       = PROD_W + 3;          // signed sum with headroom
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 136;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_OFFSET  = 3'd4;

  localparam logic BO_MOTOROLA = 1'b0;
  localparam logic BO_INTEL    = 1'b1;

  localparam logic [LEN_W-1:0]    MAX_LEN    = 7'd64;
  localparam logic [NBYTES_W-1:0] MAX_NBYTES = 4'd8;

  localparam logic [PHYS_W-1:0] PHYS_MAX = {1'b0, {(PHYS_W-1){1'b1}}};
  localparam logic [PHYS_W-1:0] PHYS_MIN = {1'b1, {(PHYS_W-1){1'b0}}};

  typedef struct packed {
    logic [START_W-1:0]         start_bit;
    logic [LEN_W-1:0]           signal_length;
    logic                       byte_order;
    logic signed [FACTOR_W-1:0] scale_factor;
    logic signed [OFFSET_W-1:0] scale_offset;
  } cfg_t;

endpackage

>>> rtl/core/csx_extract.sv
// Stage 1: extracts the configured signal bits from the payload.
// Intel and Motorola paths are barrel shifts; result is registered.
// Depends on csx_pkg.
`timescale 1ns / 1ps

module csx_extract (
  input  logic                           clk,
  input  logic                           rst_n,
  input  csx_pkg::cfg_t                  cfg,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [csx_pkg::PAYLOAD_W-1:0]  payload_i,
  input  logic [csx_pkg::NBYTES_W-1:0]   nbytes_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [csx_pkg::RAW_W-1:0]      raw_o
);

  logic                          valid_r, valid_nxt;
  logic [csx_pkg::RAW_W-1:0]     raw_r, raw_nxt;
  logic [csx_pkg::LEN_W-1:0]     len;
  logic [csx_pkg::NBYTES_W-1:0]  nb;
  logic [csx_pkg::PAYLOAD_W-1:0] intel_v;
  logic [csx_pkg::PAYLOAD_W-1:0] be;
  logic [csx_pkg::PAYLOAD_W-1:0] moto_t;
  logic [csx_pkg::START_W-1:0]   seq;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign raw_o   = raw_r;

  always_comb begin
    len = (cfg.signal_length > csx_pkg::MAX_LEN) ? csx_pkg::MAX_LEN : cfg.signal_length;
    nb  = (nbytes_i > csx_pkg::MAX_NBYTES) ? csx_pkg::MAX_NBYTES : nbytes_i;

    // Intel: drop bytes past the count, shift down, keep len bits.
    intel_v = payload_i & ~({csx_pkg::PAYLOAD_W{1'b1}} << {nb, 3'b000});
    intel_v = (intel_v >> cfg.start_bit) & ~({csx_pkg::PAYLOAD_W{1'b1}} << len);

    // Motorola: byte-reverse so sequential bit 0 is the MSB, then align.
    for (int i = 0; i < 8; i++) begin
      be[csx_pkg::PAYLOAD_W-1-8*i -: 8] = payload_i[8*i +: 8];
    end
    seq    = {cfg.start_bit[5:3], ~cfg.start_bit[2:0]};
    moto_t = be << seq;
    if (len != csx_pkg::MAX_LEN) begin
      moto_t = moto_t >> (csx_pkg::MAX_LEN - len);
    end

    if (len == '0) begin
      raw_nxt = '0;
    end else if (cfg.byte_order == csx_pkg::BO_INTEL) begin
      raw_nxt = intel_v;
    end else begin
      raw_nxt = moto_t;
    end

    valid_nxt = ready_o ? valid_i : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      raw_r <= raw_nxt;
    end
  end

endmodule

>>> rtl/core/csx_mul.sv
// Stages 2 and 3: factor magnitude times raw value as two 32x32 partial
// products, then the partial products are summed into a 96-bit magnitude.
// Depends on csx_pkg.
`timescale 1ns / 1ps

module csx_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csx_pkg::cfg_t                 cfg,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [csx_pkg::RAW_W-1:0]     raw_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [csx_pkg::RAW_W-1:0]     raw_o,
  output logic [csx_pkg::PROD_W-1:0]    prod_o,
  output logic                          neg_o
);

  localparam int HALF_W = csx_pkg::RAW_W / 2;
  localparam int PP_W   = HALF_W + csx_pkg::FACTOR_W;

  logic                          v2_r, v2_nxt, v3_r, v3_nxt;
  logic                          s2_ready, s3_ready;
  logic [csx_pkg::FACTOR_W-1:0]  mag;
  logic                          neg;
  logic [PP_W-1:0]               pp_lo_r, pp_hi_r;
  logic [csx_pkg::RAW_W-1:0]     raw2_r, raw3_r;
  logic                          neg2_r, neg3_r;
  logic [csx_pkg::PROD_W-1:0]    prod_r, prod_nxt;

  assign s3_ready = !v3_r || ready_i;
  assign s2_ready = !v2_r || s3_ready;
  assign ready_o  = s2_ready;
  assign valid_o  = v3_r;
  assign raw_o    = raw3_r;
  assign prod_o   = prod_r;
  assign neg_o    = neg3_r;

  always_comb begin
    neg      = cfg.scale_factor[csx_pkg::FACTOR_W-1];
    mag      = neg ? (~cfg.scale_factor + 1'b1) : cfg.scale_factor;
    prod_nxt = {pp_hi_r, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pp_lo_r};
    v2_nxt   = s2_ready ? valid_i : v2_r;
    v3_nxt   = s3_ready ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && s2_ready) begin
      pp_lo_r <= {{csx_pkg::FACTOR_W{1'b0}}, raw_i[HALF_W-1:0]} * {{HALF_W{1'b0}}, mag};
      pp_hi_r <= {{csx_pkg::FACTOR_W{1'b0}}, raw_i[csx_pkg::RAW_W-1:HALF_W]} *
                 {{HALF_W{1'b0}}, mag};
      raw2_r  <= raw_i;
      neg2_r  <= neg;
    end
    if (v2_r && s3_ready) begin
      prod_r <= prod_nxt;
      raw3_r <= raw2_r;
      neg3_r <= neg2_r;
    end
  end

endmodule

>>> rtl/core/csx_sat.sv
// Stage 4: applies the sign, adds the offset and saturates to 64 bits.
// Holds the output register of the block. Depends on csx_pkg.
`timescale 1ns / 1ps

module csx_sat (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csx_pkg::cfg_t                 cfg,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [csx_pkg::RAW_W-1:0]     raw_i,
  input  logic [csx_pkg::PROD_W-1:0]    prod_i,
  input  logic                          neg_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [csx_pkg::RAW_W-1:0]     raw_o,
  output logic [csx_pkg::PHYS_W-1:0]    phys_o,
  output logic                          sat_o
);

  localparam int EXT_W = csx_pkg::SUM_W - csx_pkg::OFFSET_W;
  localparam int TOP_W = csx_pkg::SUM_W - csx_pkg::PHYS_W + 1;

  logic                          valid_r, valid_nxt;
  logic [csx_pkg::RAW_W-1:0]     raw_r;
  logic [csx_pkg::PHYS_W-1:0]    phys_r, phys_nxt;
  logic                          sat_r, sat_nxt;
  logic [csx_pkg::SUM_W-1:0]     off_ext, prod_ext, sum;
  logic [TOP_W-1:0]              top;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign raw_o   = raw_r;
  assign phys_o  = phys_r;
  assign sat_o   = sat_r;

  always_comb begin
    off_ext  = {{EXT_W{cfg.scale_offset[csx_pkg::OFFSET_W-1]}}, cfg.scale_offset};
    prod_ext = {3'b000, prod_i};
    sum      = neg_i ? (off_ext - prod_ext) : (off_ext + prod_ext);
    top      = sum[csx_pkg::SUM_W-1:csx_pkg::PHYS_W-1];
    // The sum fits when every bit from bit 63 upward agrees.
    if ((&top) || !(|top)) begin
      sat_nxt  = 1'b0;
      phys_nxt = sum[csx_pkg::PHYS_W-1:0];
    end else begin
      sat_nxt  = 1'b1;
      phys_nxt = sum[csx_pkg::SUM_W-1] ? csx_pkg::PHYS_MIN : csx_pkg::PHYS_MAX;
    end
    valid_nxt = ready_o ? valid_i : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      raw_r  <= raw_i;
      phys_r <= phys_nxt;
      sat_r  <= sat_nxt;
    end
  end

endmodule

>>> rtl/core/can_signal_extract_scale_unit.sv
// CAN signal extract and scale unit: top level with configuration registers.
// Instantiates csx_extract, csx_mul and csx_sat; depends on csx_pkg.
//
// Usage:
// - Input stream (in_tvalid/in_tready/in_tdata) carries one CAN frame per
//   transaction: the 8-byte payload and its valid byte count.
// - Output stream (out_tvalid/out_tready/out_tdata) returns one transaction
//   per frame: the raw signal bits, the scaled physical value in Q48.16 and
//   a flag that is set when the physical value was clipped.
// - Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata).
//   Registers: 0 start bit, 1 signal length, 2 byte order, 3 scale factor
//   (Q16.16), 4 scale offset (Q48.16). Write only while no frame is in flight.
// - The pipeline has four register stages: signal extraction, two 32x32
//   partial products, partial product sum, then sign, offset add and
//   saturation into the output register. out_tvalid rises once a frame has
//   passed the extract, partial product, sum and output registers.
// - Throughput is one frame per cycle while out_tready stays high; the
//   pipeline holds up to four frames.
// - When the receiver deasserts out_tready, the stages fill up behind the
//   output register and in_tready drops only once every stage holds a frame.
// - A synchronous reset (rst_n low) empties the pipeline and loads the
//   register defaults: start bit 0, length 8, Intel order, factor 1.0,
//   offset 0.
`timescale 1ns / 1ps

module can_signal_extract_scale_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: payload[63:0], payload_bytes[67:64], zero pad [71:68]
  input  logic [csx_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Output stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: raw_value[63:0], physical_value[127:64],
  // saturated[128], zero pad [135:129]
  output logic [csx_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [csx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csx_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  csx_pkg::cfg_t cfg_r, cfg_nxt;

  // Stage 1 to stage 2
  logic                          s1_valid, s1_ready;
  logic [csx_pkg::RAW_W-1:0]     s1_raw;
  // Stage 3 to stage 4
  logic                          s3_valid, s3_ready;
  logic [csx_pkg::RAW_W-1:0]     s3_raw;
  logic [csx_pkg::PROD_W-1:0]    s3_prod;
  logic                          s3_neg;
  // Output register
  logic [csx_pkg::RAW_W-1:0]     out_raw;
  logic [csx_pkg::PHYS_W-1:0]    out_phys;
  logic                          out_sat;

  // Configuration registers. Writes to unused indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        csx_pkg::CFG_START_BIT:
          cfg_nxt.start_bit = cfg_wdata[csx_pkg::START_W-1:0];
        csx_pkg::CFG_SIGNAL_LENGTH:
          cfg_nxt.signal_length = cfg_wdata[csx_pkg::LEN_W-1:0];
        csx_pkg::CFG_BYTE_ORDER:
          cfg_nxt.byte_order = cfg_wdata[0];
        csx_pkg::CFG_SCALE_FACTOR:
          cfg_nxt.scale_factor = cfg_wdata[csx_pkg::FACTOR_W-1:0];
        csx_pkg::CFG_SCALE_OFFSET:
          cfg_nxt.scale_offset = cfg_wdata[csx_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_bit     <= '0;
      cfg_r.signal_length <= 7'd8;
      cfg_r.byte_order    <= csx_pkg::BO_INTEL;
      cfg_r.scale_factor  <= 32'sh0001_0000;
      cfg_r.scale_offset  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Stage 1: signal extraction.
  csx_extract u_extract (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .valid_i   (in_tvalid),
    .ready_o   (in_tready),
    .payload_i (in_tdata[csx_pkg::PAYLOAD_W-1:0]),
    .nbytes_i  (in_tdata[csx_pkg::PAYLOAD_W +: csx_pkg::NBYTES_W]),
    .valid_o   (s1_valid),
    .ready_i   (s1_ready),
    .raw_o     (s1_raw)
  );

  // Stages 2 and 3: unsigned multiply by the factor magnitude.
  csx_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .raw_i   (s1_raw),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .raw_o   (s3_raw),
    .prod_o  (s3_prod),
    .neg_o   (s3_neg)
  );

  // Stage 4: sign, offset and saturation into the output register.
  csx_sat u_sat (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .raw_i   (s3_raw),
    .prod_i  (s3_prod),
    .neg_i   (s3_neg),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .raw_o   (out_raw),
    .phys_o  (out_phys),
    .sat_o   (out_sat)
  );

  assign out_tdata = {7'b0000000, out_sat, out_phys, out_raw};

endmodule

>>> rtl/core/csx_checker.sv
// Port-level checker for can_signal_extract_scale_unit, attached by bind.
// Depends on the top level's port list.
`timescale 1ns / 1ps

module csx_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);

  // A stalled output transaction holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A receiver that takes results never stalls the input side.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  // A clipped result sits exactly on one of the two bounds.
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[128] |->
      (out_tdata[127:64] == 64'h8000_0000_0000_0000) ||
      (out_tdata[127:64] == 64'h7FFF_FFFF_FFFF_FFFF))
    else $error("saturated flag without a bound value");

endmodule

bind can_signal_extract_scale_unit csx_checker u_csx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> test/tb_can_signal_extract_scale_unit.sv
// Self-checking testbench for the CAN signal extract and scale unit.
// Drives frames through the input stream, predicts every decode, checks the output stream.
// Depends on csx_pkg and can_signal_extract_scale_unit.
`timescale 1ns / 1ps

module tb_can_signal_extract_scale_unit;

  // One frame waiting to be driven, together with the idle cycles that come
  // before it and a flag that holds it back until the pipeline has drained.
  typedef struct {
    logic [csx_pkg::PAYLOAD_W-1:0] payload;
    logic [csx_pkg::NBYTES_W-1:0]  nbytes;
    int unsigned                   gap;
    bit                            drain;
  } pending_frame_t;

  // One predicted decode, in the field order of the output transaction.
  typedef struct {
    logic [csx_pkg::RAW_W-1:0]  raw_value;
    logic [csx_pkg::PHYS_W-1:0] physical_value;
    logic                       saturated;
  } decoded_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [csx_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [csx_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_we = 1'b0;
  logic [csx_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [csx_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Frames still to be driven and decodes still to come back, oldest first.
  pending_frame_t frames_to_send[$];
  decoded_t       expected_decodes[$];

  // The testbench's own copy of the configuration registers, starting at
  // the reset defaults of the block.
  csx_pkg::cfg_t cfg_shadow = '{start_bit: 6'd0, signal_length: 7'd8,
                                byte_order: csx_pkg::BO_INTEL,
                                scale_factor: 32'sd65536, scale_offset: 64'sd0};

  // Largest idle stretch each side draws per transaction; zero means the
  // side runs flat out.
  int unsigned tx_idle_max = 12;
  int unsigned rx_idle_max = 12;

  int unsigned gap_count  = 0;
  int unsigned stall_left = 0;
  int unsigned err_count  = 0;

  can_signal_extract_scale_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predicts the decode of one frame under a given configuration. Intel
  // order reads the payload as a little-endian word with bytes past the
  // count cleared, then takes the signal LSB first from the start bit.
  // Motorola order byte-swaps the payload, renumbers the start bit to its
  // sequential position and takes the signal MSB first; the byte count is
  // ignored there. The scaling is done exactly in a wide signed word and
  // then clipped to the signed 64-bit range.
  function automatic decoded_t decode_signal(input csx_pkg::cfg_t c,
                                             input logic [csx_pkg::PAYLOAD_W-1:0] payload,
                                             input logic [csx_pkg::NBYTES_W-1:0] nbytes);
    decoded_t                            d;
    logic [csx_pkg::LEN_W-1:0]           len;
    logic [csx_pkg::NBYTES_W-1:0]        n;
    logic [csx_pkg::RAW_W-1:0]           v;
    logic [csx_pkg::RAW_W-1:0]           swapped;
    logic [csx_pkg::START_W-1:0]         seq;
    logic signed [csx_pkg::RAW_W:0]      raw_s;
    logic signed [csx_pkg::FACTOR_W-1:0] fac_s;
    logic signed [csx_pkg::OFFSET_W-1:0] ofs_s;
    logic signed [97:0]                  total;
    int i;
    // A length above 64 behaves as 64; a length of zero yields no bits.
    len = (c.signal_length > csx_pkg::MAX_LEN) ? csx_pkg::MAX_LEN : c.signal_length;
    if (len == '0) begin
      v = '0;
    end else if (c.byte_order == csx_pkg::BO_INTEL) begin
      n = (nbytes > csx_pkg::MAX_NBYTES) ? csx_pkg::MAX_NBYTES : nbytes;
      v = payload;
      if (n < csx_pkg::MAX_NBYTES) v = v & ((64'd1 << (8 * n)) - 64'd1);
      v = v >> c.start_bit;
      if (len < csx_pkg::MAX_LEN) v = v & ((64'd1 << len) - 64'd1);
    end else begin
      for (i = 0; i < 8; i++) swapped[63-8*i -: 8] = payload[8*i +: 8];
      // Within a byte the sequential index counts down from bit 7.
      seq = {c.start_bit[5:3], ~c.start_bit[2:0]};
      v = swapped << seq;
      if (len < csx_pkg::MAX_LEN) v = v >> (csx_pkg::MAX_LEN - len);
    end
    raw_s = {1'b0, v};
    fac_s = c.scale_factor;
    ofs_s = c.scale_offset;
    total = raw_s * fac_s + ofs_s;
    d.raw_value = v;
    if (total[97:63] == {35{total[63]}}) begin
      d.physical_value = total[63:0];
      d.saturated      = 1'b0;
    end else begin
      d.physical_value = total[97] ? csx_pkg::PHYS_MIN : csx_pkg::PHYS_MAX;
      d.saturated      = 1'b1;
    end
    return d;
  endfunction

  // Queues one frame; its leading idle stretch follows the current sender setting.
  task automatic queue_frame(input logic [csx_pkg::PAYLOAD_W-1:0] payload,
                             input logic [csx_pkg::NBYTES_W-1:0] nbytes, input bit drain);
    pending_frame_t f;
    f.payload = payload;
    f.nbytes  = nbytes;
    f.gap     = $urandom_range(tx_idle_max, 0);
    f.drain   = drain;
    frames_to_send.insert(frames_to_send.size(), f);
  endtask

  // Returns once every queued frame has been sent and every decode has come
  // back. The check runs at the falling edge, when the driver and the
  // monitor have settled.
  task automatic wait_idle();
    while (frames_to_send.size() != 0 || in_tvalid || expected_decodes.size() != 0)
      @(negedge clk);
  endtask

  // Writes all five registers on consecutive cycles. The unused upper bits
  // of the write data carry junk, which the narrow registers must drop.
  task automatic configure(input logic [csx_pkg::START_W-1:0] sb,
                           input logic [csx_pkg::LEN_W-1:0] len,
                           input logic bo, input logic [csx_pkg::FACTOR_W-1:0] fac,
                           input logic [csx_pkg::OFFSET_W-1:0] ofs);
    logic [csx_pkg::CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= csx_pkg::CFG_START_BIT;
    cfg_wdata <= {junk[63:csx_pkg::START_W], sb};
    @(posedge clk);
    cfg_index <= csx_pkg::CFG_SIGNAL_LENGTH;
    cfg_wdata <= {junk[63:csx_pkg::LEN_W], len};
    @(posedge clk);
    cfg_index <= csx_pkg::CFG_BYTE_ORDER;
    cfg_wdata <= {junk[63:1], bo};
    @(posedge clk);
    cfg_index <= csx_pkg::CFG_SCALE_FACTOR;
    cfg_wdata <= {junk[63:csx_pkg::FACTOR_W], fac};
    @(posedge clk);
    cfg_index <= csx_pkg::CFG_SCALE_OFFSET;
    cfg_wdata <= ofs;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow.start_bit     = sb;
    cfg_shadow.signal_length = len;
    cfg_shadow.byte_order    = bo;
    cfg_shadow.scale_factor  = fac;
    cfg_shadow.scale_offset  = ofs;
  endtask

  // Input driver. While a frame is offered and not yet taken, everything
  // holds. Otherwise a transaction that completed at this edge gets its
  // prediction queued, and the next frame is offered once its idle stretch
  // has passed and, if it asks for it, the pipeline has emptied.
  always @(posedge clk) begin : drive_frames
    pending_frame_t f;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_count <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid)
        expected_decodes.insert(expected_decodes.size(),
                                decode_signal(cfg_shadow,
                                              in_tdata[csx_pkg::PAYLOAD_W-1:0],
                                              in_tdata[csx_pkg::PAYLOAD_W +:
                                                       csx_pkg::NBYTES_W]));
      if (frames_to_send.size() == 0 ||
          (frames_to_send[0].drain && expected_decodes.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else if (gap_count < frames_to_send[0].gap) begin
        in_tvalid <= 1'b0;
        gap_count <= gap_count + 1;
      end else begin
        f = frames_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(csx_pkg::IN_TDATA_W-csx_pkg::PAYLOAD_W-csx_pkg::NBYTES_W){1'b0}},
                      f.nbytes, f.payload};
        gap_count <= 0;
      end
    end
  end

  // Output monitor. Each completed transaction is checked field by field
  // against the oldest prediction; after it, the receiver draws how many
  // cycles it keeps out_tready low before taking the next one.
  always @(posedge clk) begin : collect_results
    decoded_t    want;
    int unsigned n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      if (expected_decodes.size() == 0) begin
        $error("unexpected output transaction, tdata %h", out_tdata);
        err_count++;
      end else begin
        want = expected_decodes.pop_front();
        if (out_tdata[csx_pkg::RAW_W-1:0] !== want.raw_value) begin
          $error("raw_value: expected %h, got %h", want.raw_value,
                 out_tdata[csx_pkg::RAW_W-1:0]);
          err_count++;
        end
        if (out_tdata[csx_pkg::RAW_W +: csx_pkg::PHYS_W] !== want.physical_value) begin
          $error("physical_value: expected %h, got %h", want.physical_value,
                 out_tdata[csx_pkg::RAW_W +: csx_pkg::PHYS_W]);
          err_count++;
        end
        if (out_tdata[csx_pkg::RAW_W+csx_pkg::PHYS_W] !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated,
                 out_tdata[csx_pkg::RAW_W+csx_pkg::PHYS_W]);
          err_count++;
        end
      end
      n = $urandom_range(rx_idle_max, 0);
      stall_left <= n;
      out_tready <= (n == 0);
    end else if (!out_tready) begin
      if (stall_left <= 1) begin
        out_tready <= 1'b1;
        stall_left <= 0;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [csx_pkg::START_W-1:0]   sb;
    logic [csx_pkg::LEN_W-1:0]     len;
    logic                          bo;
    logic [csx_pkg::FACTOR_W-1:0]  fac;
    logic [csx_pkg::OFFSET_W-1:0]  ofs;
    logic [csx_pkg::PAYLOAD_W-1:0] payload;
    logic [csx_pkg::NBYTES_W-1:0]  nbytes;
    logic [31:0]                   r;
    int phase;
    int k;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The reset defaults come first, untouched: one byte
    // taken from bit 0 in Intel order with unit scaling.
    queue_frame(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
    wait_idle();

    // Intel signal that runs past bit 63, byte counts above eight and just short of it.
    configure(6'd60, 7'd16, csx_pkg::BO_INTEL, 32'h0001_0000, 64'd0);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0);
    queue_frame(64'h8000_0000_0000_0000, 4'd7, 1'b0);
    wait_idle();

    // Motorola signal covering the whole payload, negated onto the top offset;
    // the zero byte count must not matter in this order.
    configure(6'd7, 7'd64, csx_pkg::BO_MOTOROLA, 32'hFFFF_0000, csx_pkg::PHYS_MAX);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
    queue_frame(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
    queue_frame(64'd0, 4'd8, 1'b0);
    wait_idle();

    // Motorola from the least significant bit of byte 0: the tail runs past
    // the eighth byte and reads as zero.
    configure(6'd0, 7'd64, csx_pkg::BO_MOTOROLA, 32'h0001_0000, 64'd0);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0);
    queue_frame(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
    wait_idle();

    // Zero length: only the offset comes out.
    configure(6'd0, 7'd0, csx_pkg::BO_MOTOROLA, 32'h7FFF_FFFF, csx_pkg::PHYS_MIN);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
    queue_frame(64'hA5A5_5A5A_0F0F_F0F0, 4'd5, 1'b0);
    wait_idle();

    // Length above 64 acts as 64; start bit 63 leaves a single bit, and the
    // largest factor on the largest offset clips high.
    configure(6'd63, 7'd127, csx_pkg::BO_INTEL, 32'h7FFF_FFFF, csx_pkg::PHYS_MAX);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
    queue_frame(64'h7FFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
    wait_idle();

    // Most negative factor on a full-width raw value clips low.
    configure(6'd0, 7'd64, csx_pkg::BO_INTEL, 32'h8000_0000, csx_pkg::PHYS_MIN);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
    queue_frame(64'd0, 4'd8, 1'b0);
    wait_idle();

    // Largest positive factor on a full-width raw value clips high.
    configure(6'd0, 7'd64, csx_pkg::BO_INTEL, 32'h7FFF_FFFF, 64'd0);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
    queue_frame(64'h0000_0000_0001_0000, 4'd8, 1'b0);
    wait_idle();

    // Motorola single bit at the far end of the last byte, then a signal
    // that crosses byte boundaries.
    configure(6'd56, 7'd1, csx_pkg::BO_MOTOROLA, 32'h0000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_frame(64'h0100_0000_0000_0000, 4'd1, 1'b0);
    queue_frame(64'hFEFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
    wait_idle();
    configure(6'd3, 7'd12, csx_pkg::BO_MOTOROLA, 32'h0002_8000, 64'h0000_0000_0001_0000);
    queue_frame(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
    queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd2, 1'b0);
    wait_idle();

    // Random part: 25 phases of 50 frames, each with a fresh configuration
    // and its own idle pattern on both sides.
    for (phase = 0; phase < 25; phase++) begin
      case ($urandom_range(4, 0))
        0:       sb = 6'd0;
        1:       sb = 6'd63;
        default: begin
          r  = $urandom_range(63, 0);
          sb = r[csx_pkg::START_W-1:0];
        end
      endcase
      case ($urandom_range(5, 0))
        0:       len = csx_pkg::MAX_LEN;
        1: begin
          r   = $urandom_range(127, 0);
          len = r[csx_pkg::LEN_W-1:0];
        end
        2: begin
          r   = $urandom_range(16, 1);
          len = r[csx_pkg::LEN_W-1:0];
        end
        default: begin
          r   = $urandom_range(64, 1);
          len = r[csx_pkg::LEN_W-1:0];
        end
      endcase
      r  = $urandom_range(1, 0);
      bo = r[0];
      case ($urandom_range(5, 0))
        0:       fac = 32'h7FFF_FFFF;
        1:       fac = 32'h8000_0000;
        2:       fac = $urandom;
        default: fac = $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
      endcase
      r = $urandom;
      case ($urandom_range(5, 0))
        0:       ofs = csx_pkg::PHYS_MAX;
        1:       ofs = csx_pkg::PHYS_MIN;
        2:       ofs = {$urandom, $urandom};
        default: ofs = {{32{r[31]}}, r};
      endcase
      configure(sb, len, bo, fac, ofs);

      // Some phases run one or both sides without any idling.
      case ($urandom_range(3, 0))
        0: begin tx_idle_max = 0;  rx_idle_max = 0;  end
        1: begin tx_idle_max = 12; rx_idle_max = 0;  end
        2: begin tx_idle_max = 0;  rx_idle_max = 12; end
        default: begin tx_idle_max = 12; rx_idle_max = 12; end
      endcase

      for (k = 0; k < 50; k++) begin
        case ($urandom_range(9, 0))
          0:       payload = '0;
          1:       payload = '1;
          default: payload = {$urandom, $urandom};
        endcase
        if ($urandom_range(9, 0) == 0) r = $urandom_range(15, 9);
        else                           r = $urandom_range(8, 0);
        nbytes = r[csx_pkg::NBYTES_W-1:0];
        // Now and then the sender holds back until every decode is in.
        queue_frame(payload, nbytes, $urandom_range(39, 0) == 0);
      end
      wait_idle();
    end

    // Let the pipeline run empty for a while so that a stray transaction shows up.
    repeat (12) @(posedge clk);
    if (err_count == 0) $display("Verification passed");
    else                $display("Verification failed");
    $finish;
  end

endmodule
